// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on aclk outside reset
`define SCS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on aclk outside reset
`define SCS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/scs_pkg.sv =====
`timescale 1ns / 1ps

package scs_pkg;

    localparam logic [11:0] CLOSE_PULSE_DEFAULT = 12'd1000;
    localparam logic [11:0] PARK_PULSE_DEFAULT  = 12'd2000;
    localparam logic [15:0] PULSE_MIN_US        = 16'd400;
    localparam logic [15:0] PULSE_MAX_US        = 16'd2700;

    localparam int CFG_INDEX_W = 3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SETTLE_MS         = 3'd0,
        CFG_SETTLE_TIMEOUT_MS = 3'd1,
        CFG_FEED_TIMEOUT_MS   = 3'd2,
        CFG_TOP_RATE_SPS      = 3'd3,
        CFG_RATE_INC_SPS      = 3'd4,
        CFG_INC_PERIOD_MS     = 3'd5,
        CFG_CUT_COUNT         = 3'd6,
        CFG_OPEN_PULSE_US     = 3'd7
    } cfg_index_t;

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_START = 2'd1,
        ACT_ABORT = 2'd2,
        ACT_TEST  = 2'd3
    } act_t;

    typedef enum logic [2:0] {
        EV_NONE  = 3'd0,
        EV_START = 3'd1,
        EV_FEED  = 3'd2,
        EV_DONE  = 3'd3,
        EV_ABORT = 3'd4
    } ev_t;

    typedef struct packed {
        logic [15:0] settle_ms;
        logic [15:0] settle_timeout_ms;
        logic [31:0] feed_timeout_ms;
        logic [15:0] top_rate_sps;
        logic [15:0] rate_inc_sps;
        logic [15:0] inc_period_ms;
        logic [7:0]  cut_count;
        logic [11:0] open_pulse_us;
    } cfg_t;

    typedef struct packed {
        act_t        action;
        logic [31:0] now_ms;
        logic        with_lane;
        logic        with_feed;
        logic [31:0] initial_feed_ms;
        logic [31:0] repeat_feed_ms;
        logic [15:0] test_pulse_us;
    } item_t;

    typedef struct packed {
        logic [11:0] servo_pulse_us;
        logic        servo_on;
        logic        motor_on;
        logic [15:0] motor_rate_sps;
        logic        busy;
        ev_t         ev;
    } res_t;

    function automatic logic [11:0] clamp_pulse(input logic [15:0] us);
        logic [11:0] r;
        if (us < PULSE_MIN_US) begin
            r = PULSE_MIN_US[11:0];
        end else if (us > PULSE_MAX_US) begin
            r = PULSE_MAX_US[11:0];
        end else begin
            r = us[11:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/scs_cfg.sv =====
`timescale 1ns / 1ps

module scs_cfg (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [scs_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [31:0]                        cfg_data,
    output scs_pkg::cfg_t                      cfg
);
    import scs_pkg::*;

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.settle_ms         <= 16'd500;
            cfg_reg.settle_timeout_ms <= 16'd2000;
            cfg_reg.feed_timeout_ms   <= 32'd10000;
            cfg_reg.top_rate_sps      <= 16'd2000;
            cfg_reg.rate_inc_sps      <= 16'd200;
            cfg_reg.inc_period_ms     <= 16'd10;
            cfg_reg.cut_count         <= 8'd1;
            cfg_reg.open_pulse_us     <= 12'd1500;
        end else if (cfg_valid) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_SETTLE_MS:         cfg_reg.settle_ms         <= cfg_data[15:0];
                CFG_SETTLE_TIMEOUT_MS: cfg_reg.settle_timeout_ms <= cfg_data[15:0];
                CFG_FEED_TIMEOUT_MS:   cfg_reg.feed_timeout_ms   <= cfg_data;
                CFG_TOP_RATE_SPS:      cfg_reg.top_rate_sps      <= cfg_data[15:0];
                CFG_RATE_INC_SPS:      cfg_reg.rate_inc_sps      <= cfg_data[15:0];
                CFG_INC_PERIOD_MS:     cfg_reg.inc_period_ms     <= cfg_data[15:0];
                CFG_CUT_COUNT:         cfg_reg.cut_count         <= cfg_data[7:0];
                CFG_OPEN_PULSE_US:     cfg_reg.open_pulse_us     <= cfg_data[11:0];
                default:               cfg_reg <= cfg_reg;
            endcase
        end
    end

endmodule

// ===== rtl/scs_core.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module scs_core #(
    parameter logic [11:0] CLOSE_PULSE_US = scs_pkg::CLOSE_PULSE_DEFAULT,
    parameter logic [11:0] PARK_PULSE_US  = scs_pkg::PARK_PULSE_DEFAULT
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           fire,
    input  scs_pkg::item_t item,
    input  scs_pkg::cfg_t  cfg,
    output scs_pkg::res_t  res
);
    import scs_pkg::*;

    typedef enum logic [12:0] {
        PH_IDLE         = 13'b0000000000001,
        PH_BOOT_PARK    = 13'b0000000000010,
        PH_TEST         = 13'b0000000000100,
        PH_OPENING      = 13'b0000000001000,
        PH_OPEN_WAIT    = 13'b0000000010000,
        PH_FEEDING      = 13'b0000000100000,
        PH_FEED_WAIT    = 13'b0000001000000,
        PH_CLOSING      = 13'b0000010000000,
        PH_CLOSE_WAIT   = 13'b0000100000000,
        PH_REOPENING    = 13'b0001000000000,
        PH_REOPEN_WAIT  = 13'b0010000000000,
        PH_REPEAT_CHECK = 13'b0100000000000,
        PH_DONE         = 13'b1000000000000
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic        lane_reg, lane_next;
    logic [31:0] start_reg, start_next;
    logic [31:0] first_win_reg, first_win_next;
    logic [31:0] later_win_reg, later_win_next;
    logic [31:0] active_win_reg, active_win_next;
    logic [7:0]  cuts_reg, cuts_next;
    logic [15:0] ramp_rate_reg, ramp_rate_next;
    logic [31:0] ramp_last_reg, ramp_last_next;
    logic [11:0] pulse_reg, pulse_next;
    logic        servo_en_reg, servo_en_next;
    logic        motor_reg, motor_next;

    logic [31:0] age;
    logic [31:0] ramp_age;
    logic [16:0] ramp_sum;
    logic [31:0] win_sel;
    logic        abort_now;
    logic        settle_late;
    logic        settle_done;
    ev_t         ev;

    assign age         = item.now_ms - start_reg;
    assign ramp_age    = item.now_ms - ramp_last_reg;
    assign ramp_sum    = {1'b0, ramp_rate_reg} + {1'b0, cfg.rate_inc_sps};
    assign win_sel     = (cuts_reg == 8'd0) ? first_win_reg : later_win_reg;
    assign settle_late = age > {16'd0, cfg.settle_timeout_ms};
    assign settle_done = age >= {16'd0, cfg.settle_ms};

    always_comb begin
        phase_next      = phase_reg;
        lane_next       = lane_reg;
        start_next      = start_reg;
        first_win_next  = first_win_reg;
        later_win_next  = later_win_reg;
        active_win_next = active_win_reg;
        cuts_next       = cuts_reg;
        ramp_rate_next  = ramp_rate_reg;
        ramp_last_next  = ramp_last_reg;
        pulse_next      = pulse_reg;
        servo_en_next   = servo_en_reg;
        motor_next      = motor_reg;
        abort_now       = 1'b0;
        ev              = EV_NONE;

        unique case (item.action)
            ACT_TICK: begin
                unique case (phase_reg)
                    PH_BOOT_PARK, PH_TEST: begin
                        if (settle_done) begin
                            servo_en_next = 1'b0;
                            phase_next    = PH_IDLE;
                        end
                    end
                    PH_OPENING, PH_REOPENING: begin
                        pulse_next    = clamp_pulse({4'd0, cfg.open_pulse_us});
                        servo_en_next = 1'b1;
                        start_next    = item.now_ms;
                        phase_next    = (phase_reg == PH_OPENING) ? PH_OPEN_WAIT
                                                                  : PH_REOPEN_WAIT;
                    end
                    PH_OPEN_WAIT, PH_CLOSE_WAIT: begin
                        if (settle_late) begin
                            abort_now = 1'b1;
                        end else if (settle_done) begin
                            start_next = item.now_ms;
                            phase_next = (phase_reg == PH_OPEN_WAIT) ? PH_FEEDING
                                                                     : PH_REOPENING;
                        end
                    end
                    PH_REOPEN_WAIT: begin
                        if (settle_late) begin
                            abort_now = 1'b1;
                        end else if (settle_done) begin
                            phase_next = PH_REPEAT_CHECK;
                        end
                    end
                    PH_FEEDING: begin
                        ev              = EV_FEED;
                        active_win_next = win_sel;
                        if (lane_reg && win_sel != 32'd0) begin
                            motor_next     = 1'b1;
                            ramp_rate_next = cfg.rate_inc_sps;
                            ramp_last_next = item.now_ms;
                        end else begin
                            ramp_rate_next = 16'd0;
                        end
                        start_next = item.now_ms;
                        phase_next = PH_FEED_WAIT;
                    end
                    PH_FEED_WAIT: begin
                        if (lane_reg && ramp_rate_reg < cfg.top_rate_sps && !ramp_age[31]
                            && ramp_age >= {16'd0, cfg.inc_period_ms}) begin
                            ramp_rate_next = (ramp_sum > {1'b0, cfg.top_rate_sps})
                                           ? cfg.top_rate_sps : ramp_sum[15:0];
                            ramp_last_next = item.now_ms;
                        end
                        if (age >= active_win_reg) begin
                            if (lane_reg && active_win_reg != 32'd0) begin
                                motor_next = 1'b0;
                            end
                            start_next = item.now_ms;
                            phase_next = PH_CLOSING;
                        end else if (age > cfg.feed_timeout_ms) begin
                            abort_now = 1'b1;
                        end
                    end
                    PH_CLOSING: begin
                        pulse_next    = clamp_pulse({4'd0, CLOSE_PULSE_US});
                        servo_en_next = 1'b1;
                        start_next    = item.now_ms;
                        phase_next    = PH_CLOSE_WAIT;
                    end
                    PH_REPEAT_CHECK: begin
                        start_next = item.now_ms;
                        if (cfg.cut_count != 8'd0 && cuts_reg < cfg.cut_count - 8'd1) begin
                            cuts_next  = cuts_reg + 8'd1;
                            phase_next = PH_FEEDING;
                        end else begin
                            phase_next = PH_DONE;
                        end
                    end
                    PH_DONE: begin
                        pulse_next    = clamp_pulse({4'd0, PARK_PULSE_US});
                        servo_en_next = 1'b1;
                        if (settle_done) begin
                            servo_en_next = 1'b0;
                            phase_next    = PH_IDLE;
                            ev            = EV_DONE;
                        end
                    end
                    default: begin
                        phase_next = phase_reg;
                    end
                endcase
            end
            ACT_START: begin
                if (phase_reg == PH_IDLE || phase_reg == PH_BOOT_PARK) begin
                    lane_next = item.with_lane;
                    cuts_next = 8'd0;
                    if (item.with_lane && item.with_feed) begin
                        first_win_next = item.initial_feed_ms;
                        later_win_next = item.repeat_feed_ms;
                    end else begin
                        first_win_next = 32'd0;
                        later_win_next = 32'd0;
                    end
                    start_next = item.now_ms;
                    phase_next = PH_OPENING;
                    ev         = EV_START;
                end
            end
            ACT_ABORT: begin
                abort_now = (phase_reg != PH_IDLE);
            end
            ACT_TEST: begin
                motor_next    = 1'b0;
                pulse_next    = clamp_pulse(item.test_pulse_us);
                servo_en_next = 1'b1;
                phase_next    = PH_TEST;
                start_next    = item.now_ms;
            end
            default: begin
                phase_next = phase_reg;
            end
        endcase

        if (abort_now) begin
            pulse_next    = clamp_pulse({4'd0, PARK_PULSE_US});
            servo_en_next = 1'b1;
            motor_next    = 1'b0;
            phase_next    = PH_IDLE;
            ev            = EV_ABORT;
        end
    end

    always_comb begin
        res.servo_pulse_us = pulse_next;
        res.servo_on       = servo_en_next;
        res.motor_on       = motor_next;
        res.motor_rate_sps = motor_next ? ramp_rate_next : 16'd0;
        res.busy           = (phase_next != PH_IDLE);
        res.ev             = ev;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_BOOT_PARK;
            lane_reg       <= 1'b0;
            start_reg      <= 32'd0;
            first_win_reg  <= 32'd0;
            later_win_reg  <= 32'd0;
            active_win_reg <= 32'd0;
            cuts_reg       <= 8'd0;
            ramp_rate_reg  <= 16'd0;
            ramp_last_reg  <= 32'd0;
            pulse_reg      <= clamp_pulse({4'd0, PARK_PULSE_US});
            servo_en_reg   <= 1'b1;
            motor_reg      <= 1'b0;
        end else if (fire) begin
            phase_reg      <= phase_next;
            lane_reg       <= lane_next;
            start_reg      <= start_next;
            first_win_reg  <= first_win_next;
            later_win_reg  <= later_win_next;
            active_win_reg <= active_win_next;
            cuts_reg       <= cuts_next;
            ramp_rate_reg  <= ramp_rate_next;
            ramp_last_reg  <= ramp_last_next;
            pulse_reg      <= pulse_next;
            servo_en_reg   <= servo_en_next;
            motor_reg      <= motor_next;
        end
    end

    `SCS_ASSERT_IMP(a_motor_in_feed, motor_reg, phase_reg == PH_FEED_WAIT, "motor outside feed")
    `SCS_ASSERT_NXT(a_abort_idle, fire && ev == EV_ABORT, phase_reg == PH_IDLE && !motor_reg && servo_en_reg, "abort left state active")
    `SCS_ASSERT_NXT(a_done_idle, fire && ev == EV_DONE, phase_reg == PH_IDLE && !servo_en_reg, "done left servo on")

endmodule

// ===== rtl/servo_cutter_sequencer.sv =====
`timescale 1ns / 1ps
// channel   ports                          direction
// s_        action, time, windows, test    in   (valid/ready)
// m_        servo, motor, busy, event      out  (valid/ready)
// cfg_      index, data                    in   (valid/ready, always ready)
// One item per cycle sustained while m_ready stays high.
// Input register, then the phase step logic, then the result register.
// Both register stages advance together, so s_ready holds high while m_ready is high.
// Synchronous active-low reset; parks the blade with the servo on and the motor off.
// A stall on m_ stops the step stage; one more beat is buffered in the input register.

module servo_cutter_sequencer #(
    parameter logic [11:0] CLOSE_PULSE_US = scs_pkg::CLOSE_PULSE_DEFAULT,
    parameter logic [11:0] PARK_PULSE_US  = scs_pkg::PARK_PULSE_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [1:0]                      s_action,
    input  logic [31:0]                     s_now_ms,
    input  logic                            s_with_lane,
    input  logic                            s_with_feed,
    input  logic [31:0]                     s_initial_feed_ms,
    input  logic [31:0]                     s_repeat_feed_ms,
    input  logic [15:0]                     s_test_pulse_us,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [11:0]                     m_servo_pulse_us,
    output logic                            m_servo_on,
    output logic                            m_motor_on,
    output logic [15:0]                     m_motor_rate_sps,
    output logic                            m_busy_res,
    output logic [2:0]                      m_event_res,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [scs_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0]                     cfg_data
);
    import scs_pkg::*;

    cfg_t  cfg;
    item_t item_reg;
    logic  in_valid_reg;
    res_t  res;
    res_t  res_reg;
    logic  m_valid_reg;
    logic  out_free;
    logic  fire;

    assign out_free = !m_valid_reg || m_ready;
    assign fire     = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;

    scs_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    scs_core #(
        .CLOSE_PULSE_US (CLOSE_PULSE_US),
        .PARK_PULSE_US  (PARK_PULSE_US)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .item    (item_reg),
        .cfg     (cfg),
        .res     (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg.action          <= act_t'(s_action);
            item_reg.now_ms          <= s_now_ms;
            item_reg.with_lane       <= s_with_lane;
            item_reg.with_feed       <= s_with_feed;
            item_reg.initial_feed_ms <= s_initial_feed_ms;
            item_reg.repeat_feed_ms  <= s_repeat_feed_ms;
            item_reg.test_pulse_us   <= s_test_pulse_us;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            res_reg <= res;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_servo_pulse_us = res_reg.servo_pulse_us;
    assign m_servo_on       = res_reg.servo_on;
    assign m_motor_on       = res_reg.motor_on;
    assign m_motor_rate_sps = res_reg.motor_rate_sps;
    assign m_busy_res       = res_reg.busy;
    assign m_event_res      = res_reg.ev;

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import scs_pkg::*;

    localparam int          CYCLE_LIMIT = 200000;
    localparam logic [11:0] PARK_US     = PARK_PULSE_DEFAULT;
    localparam logic [11:0] CLOSE_US    = CLOSE_PULSE_DEFAULT;

    typedef enum logic [3:0] {
        PH_IDLE, PH_BOOT_PARK, PH_TEST, PH_OPENING, PH_OPEN_WAIT, PH_FEEDING, PH_FEED_WAIT,
        PH_CLOSING, PH_CLOSE_WAIT, PH_REOPENING, PH_REOPEN_WAIT, PH_REPEAT_CHECK, PH_DONE
    } cut_phase_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_action = ACT_TICK;
    logic [31:0] s_now_ms = '0;
    logic        s_with_lane = 1'b0;
    logic        s_with_feed = 1'b0;
    logic [31:0] s_initial_feed_ms = '0;
    logic [31:0] s_repeat_feed_ms = '0;
    logic [15:0] s_test_pulse_us = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [11:0] m_servo_pulse_us;
    logic        m_servo_on;
    logic        m_motor_on;
    logic [15:0] m_motor_rate_sps;
    logic        m_busy_res;
    logic [2:0]  m_event_res;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = CFG_SETTLE_MS;
    logic [31:0] cfg_data = '0;

    servo_cutter_sequencer u_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_action          (s_action),
        .s_now_ms          (s_now_ms),
        .s_with_lane       (s_with_lane),
        .s_with_feed       (s_with_feed),
        .s_initial_feed_ms (s_initial_feed_ms),
        .s_repeat_feed_ms  (s_repeat_feed_ms),
        .s_test_pulse_us   (s_test_pulse_us),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_servo_pulse_us  (m_servo_pulse_us),
        .m_servo_on        (m_servo_on),
        .m_motor_on        (m_motor_on),
        .m_motor_rate_sps  (m_motor_rate_sps),
        .m_busy_res        (m_busy_res),
        .m_event_res       (m_event_res),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // sequencer shadow state
    cfg_t        cut_cfg;
    cut_phase_t  ph;
    logic        lane;
    logic [31:0] ph_start;
    logic [31:0] win_first;
    logic [31:0] win_later;
    logic [31:0] win_active;
    logic [7:0]  cuts;
    logic [15:0] rate;
    logic [31:0] rate_last;
    logic [11:0] pulse;
    logic        servo_en;
    logic        motor_en;

    res_t        expected_outputs[$];
    res_t        oldest_expected;
    int          errors = 0;
    int          cycle_count = 0;
    bit          calm = 1'b0;
    int          pace_ms = 300;
    logic [31:0] wall_ms = '0;

    function automatic void drive_pulse(input logic [15:0] us);
        if (us < PULSE_MIN_US) begin
            pulse = PULSE_MIN_US[11:0];
        end else if (us > PULSE_MAX_US) begin
            pulse = PULSE_MAX_US[11:0];
        end else begin
            pulse = us[11:0];
        end
        servo_en = 1'b1;
    endfunction

    function automatic ev_t abort_cycle();
        if (ph == PH_IDLE) begin
            return EV_NONE;
        end
        drive_pulse({4'd0, PARK_US});
        motor_en = 1'b0;
        ph = PH_IDLE;
        return EV_ABORT;
    endfunction

    function automatic ev_t settle_step(input logic [31:0] age, input cut_phase_t nxt,
                                        input bit restart, input logic [31:0] t);
        if (age > {16'd0, cut_cfg.settle_timeout_ms}) begin
            return abort_cycle();
        end
        if (age >= {16'd0, cut_cfg.settle_ms}) begin
            if (restart) begin
                ph_start = t;
            end
            ph = nxt;
        end
        return EV_NONE;
    endfunction

    function automatic ev_t step_tick(input logic [31:0] t);
        logic [31:0] age;
        logic [31:0] gap;
        logic [16:0] sum;
        ev_t         ev;
        age = t - ph_start;
        ev = EV_NONE;
        case (ph)
            PH_BOOT_PARK, PH_TEST: begin
                if (age >= {16'd0, cut_cfg.settle_ms}) begin
                    servo_en = 1'b0;
                    ph = PH_IDLE;
                end
            end
            PH_OPENING, PH_REOPENING: begin
                drive_pulse({4'd0, cut_cfg.open_pulse_us});
                ph_start = t;
                ph = (ph == PH_OPENING) ? PH_OPEN_WAIT : PH_REOPEN_WAIT;
            end
            PH_OPEN_WAIT: begin
                ev = settle_step(age, PH_FEEDING, 1'b1, t);
            end
            PH_FEEDING: begin
                ev = EV_FEED;
                win_active = (cuts == 8'd0) ? win_first : win_later;
                if (lane && win_active != 32'd0) begin
                    motor_en = 1'b1;
                    rate = cut_cfg.rate_inc_sps;
                    rate_last = t;
                end else begin
                    rate = 16'd0;
                end
                ph_start = t;
                ph = PH_FEED_WAIT;
            end
            PH_FEED_WAIT: begin
                if (lane && rate < cut_cfg.top_rate_sps) begin
                    gap = t - rate_last;
                    if (!gap[31] && gap >= {16'd0, cut_cfg.inc_period_ms}) begin
                        sum = {1'b0, rate} + {1'b0, cut_cfg.rate_inc_sps};
                        rate = (sum > {1'b0, cut_cfg.top_rate_sps}) ? cut_cfg.top_rate_sps
                                                                    : sum[15:0];
                        rate_last = t;
                    end
                end
                // reaching the window wins over the feed timeout
                if (age >= win_active) begin
                    if (lane && win_active != 32'd0) begin
                        motor_en = 1'b0;
                    end
                    ph_start = t;
                    ph = PH_CLOSING;
                end else if (age > cut_cfg.feed_timeout_ms) begin
                    ev = abort_cycle();
                end
            end
            PH_CLOSING: begin
                drive_pulse({4'd0, CLOSE_US});
                ph_start = t;
                ph = PH_CLOSE_WAIT;
            end
            PH_CLOSE_WAIT: begin
                ev = settle_step(age, PH_REOPENING, 1'b1, t);
            end
            PH_REOPEN_WAIT: begin
                ev = settle_step(age, PH_REPEAT_CHECK, 1'b0, t);
            end
            PH_REPEAT_CHECK: begin
                ph_start = t;
                if (cut_cfg.cut_count != 8'd0 && cuts < cut_cfg.cut_count - 8'd1) begin
                    cuts = cuts + 8'd1;
                    ph = PH_FEEDING;
                end else begin
                    ph = PH_DONE;
                end
            end
            PH_DONE: begin
                drive_pulse({4'd0, PARK_US});
                if (age >= {16'd0, cut_cfg.settle_ms}) begin
                    servo_en = 1'b0;
                    ph = PH_IDLE;
                    ev = EV_DONE;
                end
            end
            default: begin
            end
        endcase
        return ev;
    endfunction

    task automatic predict_outputs(input item_t it);
        ev_t  ev;
        res_t r;
        ev = EV_NONE;
        case (it.action)
            ACT_TICK: begin
                ev = step_tick(it.now_ms);
            end
            ACT_START: begin
                if (ph == PH_IDLE || ph == PH_BOOT_PARK) begin
                    lane = it.with_lane;
                    cuts = 8'd0;
                    if (it.with_lane && it.with_feed) begin
                        win_first = it.initial_feed_ms;
                        win_later = it.repeat_feed_ms;
                    end else begin
                        win_first = 32'd0;
                        win_later = 32'd0;
                    end
                    ph_start = it.now_ms;
                    ph = PH_OPENING;
                    ev = EV_START;
                end
            end
            ACT_ABORT: begin
                ev = abort_cycle();
            end
            default: begin
                motor_en = 1'b0;
                drive_pulse(it.test_pulse_us);
                ph = PH_TEST;
                ph_start = it.now_ms;
            end
        endcase
        r.servo_pulse_us = pulse;
        r.servo_on = servo_en;
        r.motor_on = motor_en;
        r.motor_rate_sps = motor_en ? rate : 16'd0;
        r.busy = (ph != PH_IDLE);
        r.ev = ev;
        expected_outputs.push_back(r);
    endtask

    task automatic report_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_outputs.size() == 0) begin
                $display("%0t: result beat with nothing outstanding, pulse %0d event %0d",
                         $time, m_servo_pulse_us, m_event_res);
                errors++;
            end else begin
                oldest_expected = expected_outputs.pop_front();
                report_field("servo_pulse_us", oldest_expected.servo_pulse_us, m_servo_pulse_us);
                report_field("servo_on", oldest_expected.servo_on, m_servo_on);
                report_field("motor_on", oldest_expected.motor_on, m_motor_on);
                report_field("motor_rate_sps", oldest_expected.motor_rate_sps, m_motor_rate_sps);
                report_field("busy_res", oldest_expected.busy, m_busy_res);
                report_field("event_res", oldest_expected.ev, m_event_res);
            end
        end
        m_ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 25);
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("servo_cutter_sequencer: mismatch");
            $finish;
        end
    end

    task automatic send_item(input item_t it);
        while (!calm && $urandom_range(0, 99) < 25) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_action <= it.action;
        s_now_ms <= it.now_ms;
        s_with_lane <= it.with_lane;
        s_with_feed <= it.with_feed;
        s_initial_feed_ms <= it.initial_feed_ms;
        s_repeat_feed_ms <= it.repeat_feed_ms;
        s_test_pulse_us <= it.test_pulse_us;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        predict_outputs(it);
    endtask

    function automatic item_t junk_item(input act_t a);
        item_t it;
        it.action = a;
        it.now_ms = wall_ms;
        it.with_lane = 1'($urandom_range(0, 1));
        it.with_feed = 1'($urandom_range(0, 1));
        it.initial_feed_ms = $urandom();
        it.repeat_feed_ms = $urandom();
        it.test_pulse_us = 16'($urandom_range(0, 65535));
        return it;
    endfunction

    task automatic send_at(input act_t a, input logic [31:0] t);
        wall_ms = t;
        send_item(junk_item(a));
    endtask

    task automatic send_start(input logic [31:0] t, input logic with_lane, input logic with_feed,
                              input logic [31:0] w1, input logic [31:0] w2);
        item_t it;
        wall_ms = t;
        it = junk_item(ACT_START);
        it.with_lane = with_lane;
        it.with_feed = with_feed;
        it.initial_feed_ms = w1;
        it.repeat_feed_ms = w2;
        send_item(it);
    endtask

    task automatic send_test(input logic [31:0] t, input logic [15:0] us);
        item_t it;
        wall_ms = t;
        it = junk_item(ACT_TEST);
        it.test_pulse_us = us;
        send_item(it);
    endtask

    task automatic wait_results_home();
        s_valid <= 1'b0;
        while (expected_outputs.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) begin
            @(posedge aclk);
        end
        case (idx)
            CFG_SETTLE_MS:         cut_cfg.settle_ms = val[15:0];
            CFG_SETTLE_TIMEOUT_MS: cut_cfg.settle_timeout_ms = val[15:0];
            CFG_FEED_TIMEOUT_MS:   cut_cfg.feed_timeout_ms = val;
            CFG_TOP_RATE_SPS:      cut_cfg.top_rate_sps = val[15:0];
            CFG_RATE_INC_SPS:      cut_cfg.rate_inc_sps = val[15:0];
            CFG_INC_PERIOD_MS:     cut_cfg.inc_period_ms = val[15:0];
            CFG_CUT_COUNT:         cut_cfg.cut_count = val[7:0];
            default:               cut_cfg.open_pulse_us = val[11:0];
        endcase
    endtask

    // drain, let the pipeline go quiet, then reprogram every register
    task automatic apply_settings(input cfg_t c, input int pace);
        logic [31:0] junk;
        wait_results_home();
        repeat (4) @(posedge aclk);
        junk = $urandom();
        write_reg(CFG_SETTLE_MS, {junk[31:16], c.settle_ms});
        write_reg(CFG_SETTLE_TIMEOUT_MS, {junk[15:0], c.settle_timeout_ms});
        write_reg(CFG_FEED_TIMEOUT_MS, c.feed_timeout_ms);
        junk = $urandom();
        write_reg(CFG_TOP_RATE_SPS, {junk[31:16], c.top_rate_sps});
        write_reg(CFG_RATE_INC_SPS, {junk[15:0], c.rate_inc_sps});
        junk = $urandom();
        write_reg(CFG_INC_PERIOD_MS, {junk[31:16], c.inc_period_ms});
        write_reg(CFG_CUT_COUNT, {junk[31:8], c.cut_count});
        write_reg(CFG_OPEN_PULSE_US, {junk[31:12], c.open_pulse_us});
        cfg_valid <= 1'b0;
        pace_ms = pace;
    endtask

    function automatic logic [31:0] pick_window();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) begin
            return 32'd0;
        end else if (r < 15) begin
            return $urandom();
        end
        return $urandom_range(1, 4 * pace_ms + 1);
    endfunction

    // mostly well-formed cut cycles, with stray starts, aborts, tests and time jumps
    task automatic run_mixed_traffic(input int n);
        item_t it;
        act_t  a;
        int    r;
        int    roll;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            roll = $urandom_range(0, 99);
            if (roll < 2) begin
                wall_ms = $urandom();
            end else if (roll < 6) begin
                wall_ms += $urandom_range(0, 8 * pace_ms + 8);
            end else begin
                wall_ms += $urandom_range(0, pace_ms);
            end
            if (ph == PH_IDLE || ph == PH_BOOT_PARK) begin
                if (r < 60) begin
                    a = ACT_START;
                end else if (r < 72) begin
                    a = ACT_TEST;
                end else if (r < 78) begin
                    a = ACT_ABORT;
                end else begin
                    a = ACT_TICK;
                end
            end else begin
                if (r < 88) begin
                    a = ACT_TICK;
                end else if (r < 92) begin
                    a = ACT_START;
                end else if (r < 95) begin
                    a = ACT_ABORT;
                end else begin
                    a = ACT_TEST;
                end
            end
            it = junk_item(a);
            if (a == ACT_START) begin
                it.with_lane = ($urandom_range(0, 99) < 85);
                it.with_feed = ($urandom_range(0, 99) < 85);
                it.initial_feed_ms = pick_window();
                it.repeat_feed_ms = pick_window();
            end else if (a == ACT_TEST && $urandom_range(0, 1) == 0) begin
                it.test_pulse_us = 16'($urandom_range(300, 2800));
            end
            send_item(it);
        end
    endtask

    task automatic test_boot_and_pulse_clamp();
        send_at(ACT_TICK, 32'd100);
        send_start(32'd150, 1'b1, 1'b1, 32'd50, 32'd50);
        send_at(ACT_ABORT, 32'd160);
        send_test(32'd200, 16'd0);
        send_at(ACT_TICK, 32'd800);
        send_at(ACT_ABORT, 32'd900);
        send_test(32'd1000, 16'hFFFF);
        send_test(32'd1001, 16'd2701);
        send_test(32'd1002, 16'd399);
        send_start(32'd1003, 1'b1, 1'b1, 32'd10, 32'd10);
        send_at(ACT_ABORT, 32'd1004);
    endtask

    task automatic test_cycle_corners();
        cfg_t c;
        c = '{settle_ms: 16'd2, settle_timeout_ms: 16'd5, feed_timeout_ms: 32'd8,
              top_rate_sps: 16'd500, rate_inc_sps: 16'd200, inc_period_ms: 16'd1,
              cut_count: 8'd0, open_pulse_us: 12'd4000};
        apply_settings(c, 4);
        // ramp across the time wrap, then a settle timeout
        send_start(32'hFFFF_FFFC, 1'b1, 1'b1, 32'd3, 32'd7);
        send_at(ACT_TICK, 32'hFFFF_FFFC);
        send_at(ACT_TICK, 32'hFFFF_FFFE);
        send_at(ACT_TICK, 32'hFFFF_FFFE);
        send_at(ACT_TICK, 32'd0);
        send_at(ACT_TICK, 32'd1);
        send_at(ACT_TICK, 32'd1);
        send_start(32'd1, 1'b0, 1'b0, 32'd0, 32'd0);
        send_at(ACT_TICK, 32'd7);
        // window end and feed timeout on the same tick, then a full stroke to done
        send_start(32'd100, 1'b1, 1'b1, 32'd10, 32'd0);
        send_at(ACT_TICK, 32'd100);
        send_at(ACT_TICK, 32'd102);
        send_at(ACT_TICK, 32'd102);
        send_at(ACT_TICK, 32'd112);
        send_at(ACT_TICK, 32'd112);
        send_at(ACT_TICK, 32'd114);
        send_at(ACT_TICK, 32'd114);
        send_at(ACT_TICK, 32'd116);
        send_at(ACT_TICK, 32'd116);
        send_at(ACT_TICK, 32'd117);
        send_at(ACT_TICK, 32'd118);
    endtask

    task automatic test_default_cycle();
        cfg_t c;
        c = '{settle_ms: 16'd500, settle_timeout_ms: 16'd2000, feed_timeout_ms: 32'd10000,
              top_rate_sps: 16'd2000, rate_inc_sps: 16'd200, inc_period_ms: 16'd10,
              cut_count: 8'd1, open_pulse_us: 12'd1500};
        apply_settings(c, 250);
        run_mixed_traffic(140);
    endtask

    task automatic test_steady_stream();
        cfg_t c;
        c = '{settle_ms: 16'd8, settle_timeout_ms: 16'd30, feed_timeout_ms: 32'd60,
              top_rate_sps: 16'd1000, rate_inc_sps: 16'd150, inc_period_ms: 16'd3,
              cut_count: 8'd3, open_pulse_us: 12'd1200};
        apply_settings(c, 6);
        run_mixed_traffic(50);
        calm = 1'b1;
        run_mixed_traffic(150);
        calm = 1'b0;
        run_mixed_traffic(50);
    endtask

    task automatic test_random_settings();
        cfg_t c;
        for (int round = 0; round < 4; round++) begin
            c.settle_ms = 16'($urandom_range(0, 12));
            c.settle_timeout_ms = ($urandom_range(0, 99) < 15)
                                  ? 16'($urandom_range(0, c.settle_ms))
                                  : 16'(c.settle_ms + $urandom_range(0, 20));
            c.feed_timeout_ms = $urandom_range(0, 80);
            c.top_rate_sps = ($urandom_range(0, 99) < 15) ? 16'hFFFF
                                                           : 16'($urandom_range(0, 3000));
            c.rate_inc_sps = ($urandom_range(0, 99) < 10) ? 16'hFFFF
                                                           : 16'($urandom_range(0, 1000));
            c.inc_period_ms = 16'($urandom_range(0, 6));
            c.cut_count = ($urandom_range(0, 99) < 10) ? 8'd0 : 8'($urandom_range(1, 4));
            c.open_pulse_us = 12'($urandom_range(0, 4095));
            apply_settings(c, c.settle_ms / 2 + 2);
            run_mixed_traffic(100);
        end
    endtask

    task automatic test_high_extremes();
        cfg_t c;
        c = '{settle_ms: 16'hFFFF, settle_timeout_ms: 16'hFFFF, feed_timeout_ms: 32'hFFFF_FFFF,
              top_rate_sps: 16'hFFFF, rate_inc_sps: 16'hFFFF, inc_period_ms: 16'hFFFF,
              cut_count: 8'd255, open_pulse_us: 12'hFFF};
        apply_settings(c, 30000);
        run_mixed_traffic(50);
        c = '{settle_ms: 16'd0, settle_timeout_ms: 16'hFFFF, feed_timeout_ms: 32'hFFFF_FFFF,
              top_rate_sps: 16'hFFFF, rate_inc_sps: 16'hFFFF, inc_period_ms: 16'd0,
              cut_count: 8'd255, open_pulse_us: 12'd2700};
        apply_settings(c, 10000);
        run_mixed_traffic(50);
    endtask

    task automatic test_low_extremes();
        cfg_t c;
        c = '{settle_ms: 16'd0, settle_timeout_ms: 16'd0, feed_timeout_ms: 32'd0,
              top_rate_sps: 16'd0, rate_inc_sps: 16'd0, inc_period_ms: 16'd0,
              cut_count: 8'd0, open_pulse_us: 12'd0};
        apply_settings(c, 3);
        run_mixed_traffic(60);
    endtask

    task automatic test_drain_pauses();
        cfg_t c;
        c = '{settle_ms: 16'd4, settle_timeout_ms: 16'd12, feed_timeout_ms: 32'd40,
              top_rate_sps: 16'd900, rate_inc_sps: 16'd300, inc_period_ms: 16'd2,
              cut_count: 8'd2, open_pulse_us: 12'd2200};
        apply_settings(c, 4);
        for (int grp = 0; grp < 10; grp++) begin
            run_mixed_traffic(10);
            wait_results_home();
        end
    endtask

    initial begin
        cut_cfg = '{settle_ms: 16'd500, settle_timeout_ms: 16'd2000, feed_timeout_ms: 32'd10000,
                    top_rate_sps: 16'd2000, rate_inc_sps: 16'd200, inc_period_ms: 16'd10,
                    cut_count: 8'd1, open_pulse_us: 12'd1500};
        ph = PH_BOOT_PARK;
        lane = 1'b0;
        ph_start = '0;
        win_first = '0;
        win_later = '0;
        win_active = '0;
        cuts = '0;
        rate = '0;
        rate_last = '0;
        pulse = PARK_US;
        servo_en = 1'b1;
        motor_en = 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        test_boot_and_pulse_clamp();
        test_cycle_corners();
        test_default_cycle();
        test_steady_stream();
        test_random_settings();
        test_high_extremes();
        test_low_extremes();
        test_drain_pauses();

        wait_results_home();
        repeat (8) @(posedge aclk);
        if (errors == 0) begin
            $display("servo_cutter_sequencer: match");
        end else begin
            $display("servo_cutter_sequencer: mismatch");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/scs_pkg.sv
rtl/scs_cfg.sv
rtl/scs_core.sv
rtl/servo_cutter_sequencer.sv
bench/testbench.sv
